FILE: hw/rtl/tomasulo_issue_execute_core_assert.svh
// Assertion macros shared by the core's checks
`ifndef TOMASULO_ISSUE_EXECUTE_CORE_ASSERT_SVH
`define TOMASULO_ISSUE_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication
`define TIEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TIEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/tiec_pkg.sv
`timescale 1ns / 1ps
package tiec_pkg;

  localparam int NumRegsDef     = 8;
  localparam int AddStationsDef = 3;
  localparam int MulStationsDef = 2;
  localparam int DataWidthDef   = 32;

  localparam int LatW  = 6;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_ADD_LAT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MUL_LAT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DIV_LAT = 2'd2;

  localparam logic [LatW-1:0] ADD_LAT_RST = 6'd2;
  localparam logic [LatW-1:0] MUL_LAT_RST = 6'd5;
  localparam logic [LatW-1:0] DIV_LAT_RST = 6'd10;

  localparam logic [2:0] CMD_ADD  = 3'd0;
  localparam logic [2:0] CMD_ADDI = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic               issue_valid;
    logic [2:0]         command;
    logic [2:0]         dest_reg;
    logic [2:0]         src1_reg;
    logic [2:0]         src2_reg;
    logic signed [31:0] immediate;
  } in_item_t;

  typedef struct packed {
    logic               issue_accepted;
    logic               add_done;
    logic [2:0]         add_station;
    logic signed [31:0] add_value;
    logic               mul_done;
    logic [2:0]         mul_station;
    logic signed [31:0] mul_value;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
  } dp_stat_t;

  // power-on register file contents
  function automatic logic [63:0] reg_init(input int idx);
    case (idx)
      2:       reg_init = 64'd2;
      3:       reg_init = 64'd4;
      4:       reg_init = 64'd6;
      5:       reg_init = 64'd8;
      default: reg_init = 64'd0;
    endcase
  endfunction

  // a latency setting of zero is replaced by the smallest nonzero setting
  function automatic logic [LatW-1:0] lat_fix(input logic [LatW-1:0] l);
    lat_fix = (l == '0) ? LatW'(1) : l;
  endfunction

endpackage

FILE: hw/rtl/tiec_div.sv
`timescale 1ns / 1ps
module tiec_div import tiec_pkg::*; #(
  parameter int DW = DataWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] a_i,
  input  logic [DW-1:0] b_i,
  output logic          busy_o,
  output logic [DW-1:0] q_o
);
  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW-1:0] rem_q, quo_q, den_q;
  logic          neg_q, zero_q;
  logic [DW-1:0] ma, mb;
  logic [DW:0]   sh;
  logic          ge;

  assign ma = a_i[DW-1] ? (DW'(0) - a_i) : a_i;
  assign mb = b_i[DW-1] ? (DW'(0) - b_i) : b_i;
  assign sh = {rem_q, quo_q[DW-1]};
  assign ge = (sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= ma;
      den_q  <= mb;
      neg_q  <= a_i[DW-1] ^ b_i[DW-1];
      zero_q <= (mb == '0);
    end else if (busy_q) begin
      rem_q <= ge ? DW'(sh - {1'b0, den_q}) : DW'(sh);
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign q_o    = zero_q ? '0 : (neg_q ? (DW'(0) - quo_q) : quo_q);
endmodule

FILE: hw/rtl/tiec_dp.sv
`timescale 1ns / 1ps
module tiec_dp import tiec_pkg::*; #(
  parameter int NR = NumRegsDef,
  parameter int NA = AddStationsDef,
  parameter int NM = MulStationsDef,
  parameter int DW = DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LatW-1:0]    cfg_wdata_i,
  input  in_item_t           item_i,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  output out_item_t          out_o
);
  localparam int NS = NA + NM;
  localparam int TW = $clog2(NS + 1);
  localparam int SW = $clog2(NS);
  localparam int RW = $clog2(NR);

  logic [LatW-1:0] add_lat_q, mul_lat_q, div_lat_q;
  in_item_t  item_q;
  out_item_t out_q, out_d;

  logic [DW-1:0] reg_val_q [NR];
  logic [DW-1:0] reg_val_d [NR];
  logic [TW-1:0] reg_tag_q [NR];
  logic [TW-1:0] reg_tag_d [NR];
  logic          st_busy_q [NS];
  logic          st_busy_d [NS];
  logic [1:0]    st_op_q [NS];
  logic [1:0]    st_op_d [NS];
  logic [DW-1:0] st_v1_q [NS];
  logic [DW-1:0] st_v1_d [NS];
  logic [DW-1:0] st_v2_q [NS];
  logic [DW-1:0] st_v2_d [NS];
  logic [TW-1:0] st_t1_q [NS];
  logic [TW-1:0] st_t1_d [NS];
  logic [TW-1:0] st_t2_q [NS];
  logic [TW-1:0] st_t2_d [NS];

  logic            au_busy_q, au_busy_d, mu_busy_q, mu_busy_d;
  logic [TW-1:0]   au_st_q, au_st_d, mu_st_q, mu_st_d;
  logic [LatW-1:0] au_cd_q, au_cd_d, mu_cd_q, mu_cd_d;

  logic [DW-1:0] prod_q, div_q;
  logic [SW-1:0] a_idx, m_idx;
  logic          div_start, div_busy;

  assign a_idx = SW'(au_st_q - TW'(1));
  assign m_idx = SW'(mu_st_q - TW'(1));

  assign stat_o.need_div = mu_busy_q && (mu_cd_q <= LatW'(1)) && (st_op_q[m_idx] == OP_DIV);
  assign stat_o.div_busy = div_busy;
  assign div_start       = cmd_i.calc && stat_o.need_div;
  assign out_o           = out_q;

  tiec_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (st_v1_q[m_idx]),
    .b_i     (st_v2_q[m_idx]),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  always_comb begin
    logic          a_done, m_done, found, is_add;
    logic [TW-1:0] a_tag, m_tag, t1, t2;
    logic [DW-1:0] a_val, m_val, v1, v2;
    logic          accepted;
    a_done = 1'b0; m_done = 1'b0; a_tag = '0; m_tag = '0;
    a_val = '0; m_val = '0; accepted = 1'b0; found = 1'b0;
    t1 = '0; t2 = '0; v1 = '0; v2 = '0;
    is_add = (item_q.command <= CMD_SUB);
    reg_val_d = reg_val_q; reg_tag_d = reg_tag_q;
    st_busy_d = st_busy_q; st_op_d = st_op_q;
    st_v1_d = st_v1_q; st_v2_d = st_v2_q; st_t1_d = st_t1_q; st_t2_d = st_t2_q;
    au_busy_d = au_busy_q; au_st_d = au_st_q; au_cd_d = au_cd_q;
    mu_busy_d = mu_busy_q; mu_st_d = mu_st_q; mu_cd_d = mu_cd_q;

    // add unit write-back
    if (au_busy_q) begin
      if (au_cd_q > LatW'(1)) begin
        au_cd_d = au_cd_q - LatW'(1);
      end else begin
        au_busy_d = 1'b0;
        au_cd_d   = '0;
        a_done    = 1'b1;
        a_tag     = au_st_q;
        a_val     = (st_op_q[a_idx] == OP_SUB) ? (st_v1_q[a_idx] - st_v2_q[a_idx])
                                               : (st_v1_q[a_idx] + st_v2_q[a_idx]);
        st_busy_d[a_idx] = 1'b0; st_op_d[a_idx] = '0;
        st_v1_d[a_idx] = '0; st_t1_d[a_idx] = '0;
        st_v2_d[a_idx] = '0; st_t2_d[a_idx] = '0;
        for (int i = 0; i < NR; i++) begin
          if (reg_tag_d[i] == a_tag) begin
            reg_tag_d[i] = '0; reg_val_d[i] = a_val;
          end
        end
        for (int i = 0; i < NS; i++) begin
          if (st_t1_d[i] == a_tag) begin
            st_t1_d[i] = '0; st_v1_d[i] = a_val;
          end
          if (st_t2_d[i] == a_tag) begin
            st_t2_d[i] = '0; st_v2_d[i] = a_val;
          end
        end
      end
    end

    // mul/div unit write-back
    if (mu_busy_q) begin
      if (mu_cd_q > LatW'(1)) begin
        mu_cd_d = mu_cd_q - LatW'(1);
      end else begin
        mu_busy_d = 1'b0;
        mu_cd_d   = '0;
        m_done    = 1'b1;
        m_tag     = mu_st_q;
        m_val     = (st_op_q[m_idx] == OP_MUL) ? prod_q : div_q;
        st_busy_d[m_idx] = 1'b0; st_op_d[m_idx] = '0;
        st_v1_d[m_idx] = '0; st_t1_d[m_idx] = '0;
        st_v2_d[m_idx] = '0; st_t2_d[m_idx] = '0;
        for (int i = 0; i < NR; i++) begin
          if (reg_tag_d[i] == m_tag) begin
            reg_tag_d[i] = '0; reg_val_d[i] = m_val;
          end
        end
        for (int i = 0; i < NS; i++) begin
          if (st_t1_d[i] == m_tag) begin
            st_t1_d[i] = '0; st_v1_d[i] = m_val;
          end
          if (st_t2_d[i] == m_tag) begin
            st_t2_d[i] = '0; st_v2_d[i] = m_val;
          end
        end
      end
    end

    // dispatch: lowest-indexed ready station of each kind
    if (!au_busy_d) begin
      found = 1'b0;
      for (int i = 0; i < NA; i++) begin
        if (!found && st_busy_d[i] && st_t1_d[i] == '0 && st_t2_d[i] == '0) begin
          found = 1'b1;
          au_busy_d = 1'b1;
          au_st_d   = TW'(i + 1);
          au_cd_d   = lat_fix(add_lat_q);
        end
      end
    end
    if (!mu_busy_d) begin
      found = 1'b0;
      for (int i = NA; i < NS; i++) begin
        if (!found && st_busy_d[i] && st_t1_d[i] == '0 && st_t2_d[i] == '0) begin
          found = 1'b1;
          mu_busy_d = 1'b1;
          mu_st_d   = TW'(i + 1);
          mu_cd_d   = lat_fix((st_op_d[i] == OP_MUL) ? mul_lat_q : div_lat_q);
        end
      end
    end

    // operand read happens before the destination is renamed
    if (int'(item_q.src1_reg) < NR) begin
      v1 = reg_val_d[RW'(item_q.src1_reg)];
      t1 = reg_tag_d[RW'(item_q.src1_reg)];
    end
    if (item_q.command == CMD_ADDI) begin
      v2 = DW'(item_q.immediate);
    end else if (int'(item_q.src2_reg) < NR) begin
      v2 = reg_val_d[RW'(item_q.src2_reg)];
      t2 = reg_tag_d[RW'(item_q.src2_reg)];
    end

    if (item_q.issue_valid && item_q.command <= CMD_DIV) begin
      found = 1'b0;
      for (int i = 0; i < NS; i++) begin
        if (!found && !st_busy_d[i] && ((i < NA) == is_add)) begin
          found = 1'b1;
          accepted = 1'b1;
          st_busy_d[i] = 1'b1;
          case (item_q.command)
            CMD_SUB: st_op_d[i] = OP_SUB;
            CMD_MUL: st_op_d[i] = OP_MUL;
            CMD_DIV: st_op_d[i] = OP_DIV;
            default: st_op_d[i] = OP_ADD;
          endcase
          st_v1_d[i] = v1; st_t1_d[i] = t1;
          st_v2_d[i] = v2; st_t2_d[i] = t2;
          if (int'(item_q.dest_reg) < NR) reg_tag_d[RW'(item_q.dest_reg)] = TW'(i + 1);
        end
      end
    end

    out_d.issue_accepted = accepted;
    out_d.add_done       = a_done;
    out_d.add_station    = 3'(a_tag);
    out_d.add_value      = 32'(a_val);
    out_d.mul_done       = m_done;
    out_d.mul_station    = 3'(m_tag);
    out_d.mul_value      = 32'(m_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_lat_q <= ADD_LAT_RST;
      mul_lat_q <= MUL_LAT_RST;
      div_lat_q <= DIV_LAT_RST;
      for (int i = 0; i < NR; i++) begin
        reg_val_q[i] <= DW'(reg_init(i));
        reg_tag_q[i] <= '0;
      end
      for (int i = 0; i < NS; i++) begin
        st_busy_q[i] <= 1'b0; st_op_q[i] <= '0;
        st_v1_q[i] <= '0; st_t1_q[i] <= '0;
        st_v2_q[i] <= '0; st_t2_q[i] <= '0;
      end
      au_busy_q <= 1'b0; au_st_q <= '0; au_cd_q <= '0;
      mu_busy_q <= 1'b0; mu_st_q <= '0; mu_cd_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ADD_LAT: add_lat_q <= cfg_wdata_i;
          CFG_MUL_LAT: mul_lat_q <= cfg_wdata_i;
          CFG_DIV_LAT: div_lat_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.commit) begin
        reg_val_q <= reg_val_d; reg_tag_q <= reg_tag_d;
        st_busy_q <= st_busy_d; st_op_q <= st_op_d;
        st_v1_q <= st_v1_d; st_t1_q <= st_t1_d;
        st_v2_q <= st_v2_d; st_t2_q <= st_t2_d;
        au_busy_q <= au_busy_d; au_st_q <= au_st_d; au_cd_q <= au_cd_d;
        mu_busy_q <= mu_busy_d; mu_st_q <= mu_st_d; mu_cd_q <= mu_cd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.calc) prod_q <= DW'(st_v1_q[m_idx] * st_v2_q[m_idx]);
    if (cmd_i.commit) out_q <= out_d;
  end
endmodule

FILE: hw/rtl/tiec_ctrl.sv
`timescale 1ns / 1ps
module tiec_ctrl import tiec_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_DIVW = 2'd2;
  localparam logic [1:0] S_WB   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       oval_q, oval_d;
  logic       slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = oval_q;
  assign slot_free   = !oval_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    oval_d      = oval_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = stat_i.need_div ? S_DIVW : S_WB;
      end
      S_DIVW: begin
        if (!stat_i.div_busy) state_d = S_WB;
      end
      S_WB: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          oval_d       = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end
endmodule

FILE: hw/rtl/tomasulo_issue_execute_core.sv
`timescale 1ns / 1ps
// channel   direction  handshake                   payload
// cfg       in         cfg_we_i                    cfg_idx_i, cfg_wdata_i
// in        in         in_valid_i / in_ready_o     in_item_i
// out       out        out_valid_o / out_ready_i   out_item_o
//
// One item is one machine cycle of the core, in steps from accept to result
// (accept, operand latch, commit); when the mul/div unit retires a divide, a
// wait for the radix-2 divider comes before the commit.
// Next item is taken the clock after commit, while the result register waits.
// Reset restores latencies ADD/MUL/DIV_LAT_RST, the register file and empty stations at once.
// A stalled output holds the commit until the result register frees.
module tomasulo_issue_execute_core import tiec_pkg::*; #(
  parameter int NUM_REGS     = NumRegsDef,
  parameter int ADD_STATIONS = AddStationsDef,
  parameter int MUL_STATIONS = MulStationsDef,
  parameter int DATA_WIDTH   = DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [LatW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_item_t          out_item_o
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     add_idle;
  logic     add_fields_zero;

  tiec_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  tiec_dp #(
    .NR (NUM_REGS),
    .NA (ADD_STATIONS),
    .NM (MUL_STATIONS),
    .DW (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_item_o)
  );

  assign add_idle        = out_valid_o && !out_item_o.add_done;
  assign add_fields_zero = (out_item_o.add_station == 3'd0) && (out_item_o.add_value == 32'sd0);

`include "tomasulo_issue_execute_core_assert.svh"

  `TIEC_ASSERT_NXT(a_one_item, in_valid_i && in_ready_o, !in_ready_o, "second item taken early")
  `TIEC_ASSERT_IMP(a_rose_after_wb, $rose(out_valid_o), $past(!in_ready_o), "result without work")
  `TIEC_ASSERT_IMP(a_add_idle, add_idle, add_fields_zero, "idle add fields not zero")
endmodule

FILE: tb/sv/tb_tomasulo_issue_execute_core.sv
`timescale 1ns / 1ps
module tb_tomasulo_issue_execute_core;
  import tiec_pkg::*;

  localparam int NREG = 8;
  localparam int NADD = 3;
  localparam int NST  = 5;
  localparam int LIMIT = 2000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [LatW-1:0]    cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_item_t           in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_item_o;

  tomasulo_issue_execute_core uut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // core state mirror
  logic [5:0]  lat_add, lat_mul, lat_div;
  logic [31:0] rf_val [NREG];
  logic [2:0]  rf_tag [NREG];
  logic        st_busy [NST];
  logic [1:0]  st_op [NST];
  logic [31:0] st_v1 [NST], st_v2 [NST];
  logic [2:0]  st_t1 [NST], st_t2 [NST];
  logic        au_busy, mu_busy;
  logic [2:0]  au_st, mu_st;
  logic [5:0]  au_cd, mu_cd;

  out_item_t cycle_results[$];
  int        errors = 0;
  int        cycles = 0;
  bit        quiet_out = 0;
  bit        stall_rx = 1;

  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma, mb, q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    if (mb == 0) return '0;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] alu(logic [1:0] op, logic [31:0] a, logic [31:0] b);
    case (op)
      OP_ADD:  return a + b;
      OP_SUB:  return a - b;
      OP_MUL:  return a * b;
      default: return quotient(a, b);
    endcase
  endfunction

  function automatic logic [5:0] eff_lat(logic [5:0] l);
    return (l == 0) ? 6'd1 : l;
  endfunction

  task automatic mirror_reset();
    lat_add = ADD_LAT_RST; lat_mul = MUL_LAT_RST; lat_div = DIV_LAT_RST;
    for (int i = 0; i < NREG; i++) begin
      rf_val[i] = (i >= 2 && i <= 5) ? 32'(2 * (i - 1)) : '0;
      rf_tag[i] = '0;
    end
    for (int i = 0; i < NST; i++) begin
      st_busy[i] = 0; st_op[i] = '0; st_v1[i] = '0; st_v2[i] = '0;
      st_t1[i] = '0; st_t2[i] = '0;
    end
    au_busy = 0; mu_busy = 0; au_st = '0; mu_st = '0; au_cd = '0; mu_cd = '0;
  endtask

  task automatic retire(inout logic busy, inout logic [5:0] cd, input logic [2:0] tag,
                        output logic done, output logic [31:0] v);
    int idx;
    done = 0; v = '0;
    if (!busy) return;
    if (cd > 1) begin
      cd--;
      return;
    end
    busy = 0; cd = '0;
    if (tag == 0 || tag > NST) return;
    idx = tag - 1;
    v = alu(st_op[idx], st_v1[idx], st_v2[idx]);
    st_busy[idx] = 0; st_op[idx] = '0; st_v1[idx] = '0; st_v2[idx] = '0;
    st_t1[idx] = '0; st_t2[idx] = '0;
    for (int i = 0; i < NREG; i++)
      if (rf_tag[i] == tag) begin
        rf_tag[i] = '0; rf_val[i] = v;
      end
    for (int i = 0; i < NST; i++) begin
      if (st_t1[i] == tag) begin st_t1[i] = '0; st_v1[i] = v; end
      if (st_t2[i] == tag) begin st_t2[i] = '0; st_v2[i] = v; end
    end
    done = 1;
  endtask

  function automatic int ready_station(int lo, int hi);
    for (int i = lo; i < hi; i++)
      if (st_busy[i] && st_t1[i] == 0 && st_t2[i] == 0) return i;
    return -1;
  endfunction

  task automatic run_cycle(input in_item_t it, output out_item_t r);
    logic ad, md;
    logic [31:0] av, mv;
    logic [2:0] atag, mtag;
    int s, lo, hi;
    atag = au_st; mtag = mu_st;
    retire(au_busy, au_cd, atag, ad, av);
    retire(mu_busy, mu_cd, mtag, md, mv);
    r = '0;
    r.add_done = ad; r.add_station = ad ? atag : '0; r.add_value = av;
    r.mul_done = md; r.mul_station = md ? mtag : '0; r.mul_value = mv;
    if (!au_busy) begin
      s = ready_station(0, NADD);
      if (s >= 0) begin
        au_busy = 1; au_st = 3'(s + 1); au_cd = eff_lat(lat_add);
      end
    end
    if (!mu_busy) begin
      s = ready_station(NADD, NST);
      if (s >= 0) begin
        mu_busy = 1; mu_st = 3'(s + 1);
        mu_cd = eff_lat(st_op[s] == OP_MUL ? lat_mul : lat_div);
      end
    end
    if (it.issue_valid && it.command <= CMD_DIV) begin
      lo = (it.command <= CMD_SUB) ? 0 : NADD;
      hi = (it.command <= CMD_SUB) ? NADD : NST;
      for (int i = lo; i < hi; i++) begin
        if (st_busy[i]) continue;
        case (it.command)
          CMD_ADD, CMD_ADDI: st_op[i] = OP_ADD;
          CMD_SUB:           st_op[i] = OP_SUB;
          CMD_MUL:           st_op[i] = OP_MUL;
          default:           st_op[i] = OP_DIV;
        endcase
        st_v1[i] = rf_val[it.src1_reg]; st_t1[i] = rf_tag[it.src1_reg];
        if (it.command == CMD_ADDI) begin
          st_v2[i] = it.immediate; st_t2[i] = '0;
        end else begin
          st_v2[i] = rf_val[it.src2_reg]; st_t2[i] = rf_tag[it.src2_reg];
        end
        st_busy[i] = 1;
        rf_tag[it.dest_reg] = 3'(i + 1);
        r.issue_accepted = 1;
        break;
      end
    end
  endtask

  task automatic write_lat(logic [CfgIdxW-1:0] idx, logic [5:0] v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ADD_LAT: lat_add = v;
      CFG_MUL_LAT: lat_mul = v;
      default:     lat_div = v;
    endcase
    @(posedge clk_i);
  endtask

  // send one item; a hand-typed expectation, when given, replaces the predictor's result
  task automatic send(in_item_t it, bit has_fixed = 0, out_item_t fixed = '0);
    out_item_t r;
    if (!quiet_out)
      while ($urandom_range(99) < 20) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    run_cycle(it, r);
    if (has_fixed) r = fixed;
    cycle_results = {cycle_results, r};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (cycle_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    it.issue_valid = ($urandom_range(99) < 90);
    it.command     = ($urandom_range(99) < 95) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
    it.dest_reg    = 3'($urandom_range(7));
    it.src1_reg    = 3'($urandom_range(7));
    it.src2_reg    = 3'($urandom_range(7));
    case ($urandom_range(3))
      0:       it.immediate = $urandom_range(15) - 8;
      1:       it.immediate = 32'h8000_0000 ^ $urandom_range(1);
      default: it.immediate = $urandom();
    endcase
    return it;
  endfunction

  // checker
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (cycle_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", out_item_o);
        end else begin
          e = cycle_results.pop_front();
          if (out_item_o !== e) begin
            errors++;
            if (errors <= 10) $display("mismatch exp %h got %h", e, out_item_o);
          end
        end
      end
      if (stall_rx) out_ready_i <= ($urandom_range(99) >= 20);
      else out_ready_i <= 1'b1;
      if (cycles > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  typedef struct {
    in_item_t  it;
    bit        fixed;
    out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(in_item_t it, bit fixed, out_item_t res);
    dir_row_t row;
    row.it = it; row.fixed = fixed; row.res = res;
    dir_rows = {dir_rows, row};
  endtask

  function automatic in_item_t mk(logic [2:0] c, logic [2:0] d, logic [2:0] a,
                                   logic [2:0] b, logic [31:0] imm, logic v = 1);
    in_item_t it;
    it.issue_valid = v; it.command = c; it.dest_reg = d; it.src1_reg = a;
    it.src2_reg = b; it.immediate = imm;
    return it;
  endfunction

  initial begin
    in_item_t it;
    out_item_t z;
    int n;
    z = '0;
    mirror_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle and unknown commands: nothing accepted, nothing retires; then a directed mix of items
    add_row(mk(CMD_ADD, 1, 2, 3, 0, 0), 1, z);
    add_row(mk(3'd5, 1, 2, 3, 0), 1, z);
    add_row(mk(3'd7, 1, 2, 3, 0), 1, z);
    add_row(mk(CMD_ADD, 6, 2, 3, 0), 0, z);
    add_row(mk(CMD_ADDI, 7, 5, 0, 32'h7fff_ffff), 0, z);
    add_row(mk(CMD_SUB, 1, 6, 7, 0), 0, z);
    add_row(mk(CMD_ADD, 0, 0, 0, 0), 0, z);
    add_row(mk(CMD_MUL, 2, 4, 5, 0), 0, z);
    add_row(mk(CMD_DIV, 3, 5, 0, 0), 0, z);
    add_row(mk(CMD_ADDI, 4, 0, 0, 32'h8000_0000), 0, z);
    add_row(mk(CMD_ADDI, 5, 0, 0, 32'hffff_ffff), 0, z);
    add_row(mk(CMD_DIV, 6, 4, 5, 0), 0, z);
    add_row(mk(CMD_MUL, 7, 4, 4, 0), 0, z);
    add_row(mk(CMD_DIV, 1, 7, 5, 0), 0, z);
    add_row(mk(CMD_DIV, 2, 1, 2, 0), 0, z);
    add_row(mk(CMD_ADDI, 3, 4, 0, 32'hffff_ffff), 0, z);
    add_row(mk(CMD_DIV, 0, 4, 3, 0), 0, z);
    for (int i = 0; i < 40; i++)
      add_row(mk(CMD_ADD, 0, 0, 0, 0, 0), 0, z);
    foreach (dir_rows[i]) send(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].res);
    drain();

    // min latencies, including zero-as-one, then max, random and small ones in later phases
    write_lat(CFG_ADD_LAT, 6'd0);
    write_lat(CFG_MUL_LAT, 6'd1);
    write_lat(CFG_DIV_LAT, 6'd0);
    for (int ph = 0; ph < 4; ph++) begin
      n = 0;
      while (n < 150) begin
        if (ph == 1) quiet_out = 1;
        else quiet_out = 0;
        stall_rx = (ph != 1);
        it = rand_item();
        send(it);
        n++;
        if (n == 75) begin
          // hold the sender until the pipeline has drained
          in_valid_i <= 1'b0;
          while (cycle_results.size() != 0) @(posedge clk_i);
        end
      end
      drain();
      case (ph)
        0: begin
          write_lat(CFG_ADD_LAT, 6'd63);
          write_lat(CFG_MUL_LAT, 6'd63);
          write_lat(CFG_DIV_LAT, 6'd63);
        end
        1: begin
          write_lat(CFG_ADD_LAT, 6'($urandom_range(1, 8)));
          write_lat(CFG_MUL_LAT, 6'($urandom_range(1, 8)));
          write_lat(CFG_DIV_LAT, 6'($urandom_range(1, 12)));
        end
        2: begin
          write_lat(CFG_ADD_LAT, 6'd1);
          write_lat(CFG_MUL_LAT, 6'd3);
          write_lat(CFG_DIV_LAT, 6'd2);
        end
        default: ;
      endcase
    end
    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
